/* rtl/error_diffusion_dither_defines.svh */
// assertion macros for the error diffusion dither checker
`ifndef ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EDD_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("edd check failed: same-cycle rule");

// next-cycle implication, checked out of reset
`define EDD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("edd check failed: next-cycle rule");

`endif

/* rtl/edd_pkg.sv */
// shared types, constants and helpers of the error diffusion dither
package edd_pkg;

  localparam int MAX_COLUMN_LENGTH = 1024;
  localparam int ROW_W  = $clog2(MAX_COLUMN_LENGTH);
  localparam int GREY_W = 15;
  localparam int ACC_W  = 18;
  localparam int SUM_W  = ACC_W + 2;
  localparam int LEVEL_W = 8;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [ROW_W-1:0]        row_t;

  localparam acc_t ACC_MAX = 18'sd131071;
  localparam acc_t ACC_MIN = -ACC_MAX - 18'sd1;
  localparam acc_t HALF_Q  = 18'sd8192;
  localparam acc_t ONE_Q   = 18'sd16384;
  localparam acc_t ACC_ZERO = '0;
  localparam row_t ROW_LAST = row_t'(MAX_COLUMN_LENGTH - 1);

  localparam logic [LEVEL_W-1:0] LEVEL_WHITE = 8'd250;
  localparam logic [LEVEL_W-1:0] LEVEL_BLACK = 8'd0;

  typedef struct packed {
    logic signed [GREY_W-1:0] grey;
    logic                     is_surface;
    logic                     first_column;
    logic                     first_row;
    row_t                     row;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pixel_level;
    logic               is_white;
  } result_t;

  // clamp a widened sum to the accumulator range
  function automatic acc_t sat_acc(input sum_t v);
    acc_t r;
    if (v > sum_t'(ACC_MAX)) begin
      r = ACC_MAX;
    end else if (v < sum_t'(ACC_MIN)) begin
      r = ACC_MIN;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/error_diffusion_dither.sv */
// top level of the binary error diffusion dither
// an accepted word passes the compute stage register, then the output register, to out_tvalid
// throughput: one word per cycle while the output is not stalled, limited by the store read-modify-write loop
// a stalled output holds one word and one more waits in the compute stage
// reset clears the valid flags, row position and carries; the error store
// is not cleared, the first column ignores what it reads
module error_diffusion_dither import edd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // [14:0] grey, [15] zero
  input  logic [2:0]  in_tuser,  // [0] is_surface, [1] first_column, [2] first_row
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // [7:0] pixel_level
  output logic [0:0]  out_tuser  // [0] is_white
);

  // input side: row position runs ahead of the compute stage
  row_t  row_pos_r, row_pos_nxt;
  row_t  in_row;
  logic  in_fire;

  // compute stage
  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  s1_advance;

  // forwarding of the word written in the same edge as the read
  logic  fwd_hit_r;
  acc_t  fwd_data_r;

  // store and datapath wiring
  acc_t    rd_data;
  acc_t    stored;
  acc_t    wr_data;
  result_t result;

  // output register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  assign in_fire    = in_tvalid && in_tready;
  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  // first_row restarts the column at row zero
  assign in_row      = in_tuser[2] ? '0 : row_pos_r;
  assign row_pos_nxt = (in_row == ROW_LAST) ? '0 : in_row + row_t'(1);

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        row_pos_r <= row_pos_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the compute stage, loaded with the store read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.grey         <= in_tdata[GREY_W-1:0];
      s1_item_r.is_surface   <= in_tuser[0];
      s1_item_r.first_column <= in_tuser[1];
      s1_item_r.first_row    <= in_tuser[2];
      s1_item_r.row          <= in_row;
      // a short column rereads the row the word ahead is writing now
      fwd_hit_r              <= s1_advance && (s1_item_r.row == in_row);
      fwd_data_r             <= wr_data;
    end
  end

  edd_store u_store (
    .clk     (clk),
    .wr_en   (s1_advance),
    .wr_addr (s1_item_r.row),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (in_row),
    .rd_data (rd_data)
  );

  assign stored = fwd_hit_r ? fwd_data_r : rd_data;

  edd_diffuse u_diffuse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_advance),
    .item    (s1_item_r),
    .stored  (stored),
    .result  (result),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_res_r.pixel_level;
  assign out_tuser[0] = out_res_r.is_white;

endmodule

/* rtl/edd_store.sv */
// column error store: one write port, one registered read port
module edd_store import edd_pkg::*; (
  input  logic clk,
  input  logic wr_en,
  input  row_t wr_addr,
  input  acc_t wr_data,
  input  logic rd_en,
  input  row_t rd_addr,
  output acc_t rd_data
);

  acc_t mem [MAX_COLUMN_LENGTH];
  acc_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read before write on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/edd_diffuse.sv */
// quantizer and error split with the down and diagonal carry registers
module edd_diffuse import edd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  input  acc_t    stored,
  output result_t result,
  output acc_t    wr_data
);

  acc_t row_carry_r, row_carry_nxt;
  acc_t diag_r, diag_nxt;

  acc_t carry_in, diag_in, stored_in;
  sum_t sum;
  acc_t value, err;
  sum_t err3;
  acc_t three8;
  sum_t store_sum;

  always_comb begin
    carry_in  = item.first_row ? ACC_ZERO : row_carry_r;
    diag_in   = item.first_row ? ACC_ZERO : diag_r;
    stored_in = item.first_column ? ACC_ZERO : stored;

    sum = sum_t'(item.grey) + sum_t'(stored_in) + sum_t'(carry_in);
    value = sat_acc(sum);

    if (value > HALF_Q) begin
      err = value - ONE_Q;
    end else begin
      err = value;
    end

    // 3e / 8 and e / 4, both floored
    err3 = sum_t'(err) + (sum_t'(err) <<< 1);
    three8 = acc_t'(err3 >>> 3);
    store_sum = sum_t'(three8) + sum_t'(diag_in);

    if (item.is_surface) begin
      wr_data       = sat_acc(store_sum);
      row_carry_nxt = three8;
      diag_nxt      = err >>> 2;
      if (value > HALF_Q) begin
        result.pixel_level = LEVEL_WHITE;
        result.is_white    = 1'b1;
      end else begin
        result.pixel_level = LEVEL_BLACK;
        result.is_white    = 1'b0;
      end
    end else begin
      wr_data            = diag_in;
      row_carry_nxt      = ACC_ZERO;
      diag_nxt           = ACC_ZERO;
      result.pixel_level = LEVEL_WHITE;
      result.is_white    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_carry_r <= ACC_ZERO;
      diag_r      <= ACC_ZERO;
    end else if (advance) begin
      row_carry_r <= row_carry_nxt;
      diag_r      <= diag_nxt;
    end
  end

endmodule

/* rtl/edd_checker.sv */
// port-level checks of the error diffusion dither and their bind
`include "error_diffusion_dither_defines.svh"

module edd_checker import edd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [0:0]  out_tuser
);

  logic       lvl_white;
  logic       lvl_black;
  logic       out_stall;
  logic [8:0] out_word;

  assign lvl_white = (out_tdata == LEVEL_WHITE);
  assign lvl_black = (out_tdata == LEVEL_BLACK);
  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tuser, out_tdata};

  // only black or white ever leaves the block
  `EDD_ASSERT_NOW(a_level_binary, clk, rst_n, out_tvalid, lvl_white || lvl_black)

  // the white flag follows the level
  `EDD_ASSERT_NOW(a_white_flag, clk, rst_n, out_tvalid, out_tuser[0] == lvl_white)

  // a stalled word holds
  `EDD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_word))

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
